>>> rtl/core/sbe_pkg.sv
// sbe_pkg: shared constants, opcode and status codes for the stack bytecode unit
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package sbe_pkg;
   localparam int STACK_DEPTH = 256;
   localparam int VAR_SLOTS   = 64;
   localparam int KEY_BITS    = 16;
   localparam int SP_W   = $clog2(STACK_DEPTH);
   localparam int SC_W   = $clog2(STACK_DEPTH + 1);
   localparam int VS_W   = (VAR_SLOTS > 1) ? $clog2(VAR_SLOTS) : 1;
   localparam int VC_W   = $clog2(VAR_SLOTS + 1);

   localparam logic [4:0] OP_PUSH = 5'd0, OP_LOAD = 5'd1, OP_SETVAR = 5'd2,
      OP_ADD = 5'd3, OP_SUB = 5'd4, OP_MUL = 5'd5, OP_DIV = 5'd6, OP_EQ = 5'd7,
      OP_NE = 5'd8, OP_LT = 5'd9, OP_GT = 5'd10, OP_LE = 5'd11, OP_GE = 5'd12,
      OP_EMIT = 5'd13, OP_JMP = 5'd14, OP_JZ = 5'd15, OP_HALT = 5'd16;

   localparam logic [3:0] ST_RUN = 4'd0, ST_HALT = 4'd1, ST_END = 4'd2,
      ST_OVF = 4'd3, ST_UNF = 4'd4, ST_UNDEF = 4'd5, ST_DIVZ = 4'd6,
      ST_FULL = 4'd7, ST_BADOP = 4'd8;

   typedef struct packed {
      logic       start;
      logic [4:0] op;
      logic [31:0] a;
      logic [31:0] b;
   } alu_req_type;
endpackage
`default_nettype wire

>>> rtl/core/sbe_alu.sv
// sbe_alu: shared arithmetic/compare unit; registered result for add/sub/mul/compare, bit-serial divide
// depends on sbe_pkg
`timescale 1ns / 1ps
`default_nettype none
module sbe_alu import sbe_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire alu_req_type req,
   output logic             done,
   output logic [31:0]      result
);
   logic        busy_ff, busy_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [31:0] quo_ff, quo_in, rem_ff, rem_in, div_ff, div_in;
   logic        neg_ff, neg_in;
   logic        done_ff, done_in;
   logic [31:0] res_ff, res_in;
   logic        lt_ab, lt_ba;
   logic [32:0] trial;
   logic [31:0] ma, mb, shr;

   assign lt_ab = $signed(req.a) < $signed(req.b);
   assign lt_ba = $signed(req.b) < $signed(req.a);
   assign ma = req.a[31] ? 32'(0 - req.a) : req.a;
   assign mb = req.b[31] ? 32'(0 - req.b) : req.b;
   assign shr = {rem_ff[30:0], quo_ff[31]};
   assign trial = {1'b0, shr} - {1'b0, div_ff};

   always_comb begin
      busy_in = busy_ff; cnt_in = cnt_ff; quo_in = quo_ff; rem_in = rem_ff;
      div_in = div_ff; neg_in = neg_ff; done_in = 1'b0; res_in = res_ff;
      if (busy_ff) begin
         // one quotient bit per cycle, restoring
         quo_in = {quo_ff[30:0], ~trial[32]};
         rem_in = trial[32] ? shr : trial[31:0];
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            res_in  = neg_ff ? 32'(0 - {quo_ff[30:0], ~trial[32]})
                             : {quo_ff[30:0], ~trial[32]};
         end
      end else if (req.start) begin
         done_in = 1'b1;
         case (req.op)
            OP_ADD: res_in = req.a + req.b;
            OP_SUB: res_in = req.a - req.b;
            OP_MUL: res_in = 32'(req.a * req.b);
            OP_EQ:  res_in = {31'd0, req.a == req.b};
            OP_NE:  res_in = {31'd0, req.a != req.b};
            OP_LT:  res_in = {31'd0, lt_ab};
            OP_GT:  res_in = {31'd0, lt_ba};
            OP_LE:  res_in = {31'd0, ~lt_ba};
            OP_GE:  res_in = {31'd0, ~lt_ab};
            OP_DIV: begin
               done_in = 1'b0; busy_in = 1'b1; cnt_in = 6'd32;
               quo_in = ma; rem_in = '0; div_in = mb;
               neg_in = req.a[31] ^ req.b[31];
            end
            default: res_in = '0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in;
      end
      cnt_ff <= cnt_in; quo_ff <= quo_in; rem_ff <= rem_in; div_ff <= div_in;
      neg_ff <= neg_in; res_ff <= res_in;
   end

   assign done = done_ff;
   assign result = res_ff;
endmodule
`default_nettype wire

>>> rtl/core/stack_bytecode_exec_unit.sv
// stack_bytecode_exec_unit: top level, sequencer, operand stack and variable store
// depends on sbe_pkg and sbe_alu
//
// Use: each req_ word is the instruction at the index the unit last returned.
// One rsp_ word comes back per instruction: next index, optional printed value
// and status. program_length is written over the csr_ channel by the user only
// while idle; csr_ready is always high, so the unit leaves that rule to the user.
// A stopped unit, or an index already at the end, is answered from S_RD1; other
// words go on through S_RD2 (stack reads), S_SCAN for load and store (the variable
// store is scanned one slot per cycle) and S_EXEC, where push/print/jump/jz/halt
// and decode faults finish; binary ops then wait in S_ALU, divide at one quotient
// bit per cycle. One instruction is in flight at a time; req_ready is low until
// the result word has been taken, so the next instruction is accepted at the
// earliest in the cycle after the rsp_ handshake. If the receiver stalls
// rsp_ready, the result holds and the input stays stalled.
// Reset clears stack and variable counts, index, stop flag and program_length;
// memory contents are not cleared and need no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module stack_bytecode_exec_unit import sbe_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [4:0]  req_cmd,
   input  wire logic signed [31:0] req_operand,
   input  wire logic [15:0] req_var_key,
   input  wire logic        req_first,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [15:0]      rsp_next_index,
   output logic             rsp_print_valid,
   output logic signed [31:0] rsp_print_value,
   output logic [3:0]       rsp_status,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [15:0] csr_program_length
);
   localparam logic [2:0] S_IDLE = 3'd0, S_RD1 = 3'd1, S_RD2 = 3'd2, S_SCAN = 3'd3,
      S_EXEC = 3'd4, S_ALU = 3'd5, S_DONE = 3'd6;

   logic [2:0]  st_ff, st_in;
   logic [15:0] plen_ff;
   logic [SC_W-1:0] sc_ff, sc_in;
   logic [VC_W-1:0] vc_ff, vc_in;
   logic [15:0] idx_ff, idx_in;
   logic        stop_ff, stop_in;
   logic [3:0]  lst_ff, lst_in;
   logic [4:0]  op_ff;
   logic [31:0] opnd_ff;
   logic [KEY_BITS-1:0] key_ff;
   logic        first_ff;
   logic [31:0] top_ff, top_in, nxt_ff, nxt_in;
   logic [VC_W-1:0] scan_ff, scan_in;
   logic        hit_ff, hit_in;
   logic [VS_W-1:0] slot_ff, slot_in;
   logic        rv_ff, rv_in;
   logic [15:0] rni_ff, rni_in;
   logic        rpv_ff, rpv_in;
   logic [31:0] rpval_ff, rpval_in;
   logic [3:0]  rst_ff, rst_in;

   logic [31:0] stk_mem [STACK_DEPTH];
   logic [31:0] stk_q;
   logic [SP_W-1:0] stk_ra, stk_wa;
   logic        stk_we;
   logic [31:0] stk_wd;
   logic [KEY_BITS-1:0] key_mem [VAR_SLOTS];
   logic [31:0] val_mem [VAR_SLOTS];
   logic [KEY_BITS-1:0] key_q;
   logic [31:0] val_q;
   logic [VS_W-1:0] var_ra, var_wa;
   logic        key_we, val_we;
   logic [31:0] val_wd;

   alu_req_type alu_req;
   logic        alu_done;
   logic [31:0] alu_res;

   sbe_alu u_alu (.clock(clock), .reset(reset), .req(alu_req),
      .done(alu_done), .result(alu_res));

   always_ff @(posedge clock) begin
      stk_q <= stk_mem[stk_ra];
      if (stk_we) stk_mem[stk_wa] <= stk_wd;
      key_q <= key_mem[var_ra];
      val_q <= val_mem[var_ra];
      if (key_we) key_mem[var_wa] <= key_ff;
      if (val_we) val_mem[var_wa] <= val_wd;
   end

   assign req_ready = (st_ff == S_IDLE) && !rv_ff;
   assign csr_ready = 1'b1;

   logic [15:0] nidx;
   logic [3:0]  stat;
   logic        fin;
   logic [31:0] jt;
   logic        take;

   always_comb begin
      st_in = st_ff; sc_in = sc_ff; vc_in = vc_ff; idx_in = idx_ff;
      stop_in = stop_ff; lst_in = lst_ff; top_in = top_ff; nxt_in = nxt_ff;
      scan_in = scan_ff; hit_in = hit_ff; slot_in = slot_ff;
      rv_in = rv_ff; rni_in = rni_ff; rpv_in = rpv_ff; rpval_in = rpval_ff;
      rst_in = rst_ff;
      stk_ra = '0; stk_wa = '0; stk_we = 1'b0; stk_wd = opnd_ff;
      var_ra = scan_ff[VS_W-1:0]; var_wa = slot_ff; key_we = 1'b0; val_we = 1'b0;
      val_wd = top_ff;
      alu_req = '{start: 1'b0, op: op_ff, a: nxt_ff, b: top_ff};
      nidx = idx_ff + 16'd1; stat = ST_RUN; fin = 1'b0; take = 1'b1;
      jt = opnd_ff;
      if (rv_ff && rsp_ready) rv_in = 1'b0;

      case (st_ff)
         S_IDLE: if (req_valid && req_ready) st_in = S_RD1;
         S_RD1: begin
            if (first_ff) begin
               sc_in = '0; vc_in = '0; idx_in = '0; stop_in = 1'b0; lst_in = ST_RUN;
            end
            if (!first_ff && stop_ff) begin
               st_in = S_DONE; stat = lst_ff; nidx = idx_ff; fin = 1'b1;
            end else if ((first_ff ? 16'd0 : idx_ff) >= plen_ff) begin
               stop_in = 1'b1; lst_in = ST_END; stat = ST_END; fin = 1'b1;
               nidx = first_ff ? 16'd0 : idx_ff;
            end else begin
               // read top of stack, then the one below
               stk_ra = SP_W'(sc_in - SC_W'(1));
               scan_in = '0; hit_in = 1'b0;
               st_in = S_RD2;
            end
         end
         S_RD2: begin
            stk_ra = SP_W'(sc_ff - SC_W'(2));
            top_in = stk_q;
            st_in = (op_ff == OP_LOAD || op_ff == OP_SETVAR) ? S_SCAN : S_EXEC;
         end
         S_SCAN: begin
            // one slot per cycle; data for scan_ff-1 is in key_q
            if (scan_ff != '0 && key_q == key_ff && !hit_in) begin
               hit_in = 1'b1; slot_in = VS_W'(scan_ff - VC_W'(1));
            end
            if (hit_in || scan_ff >= vc_ff) begin
               var_ra = hit_in ? slot_in : VS_W'(scan_ff - VC_W'(1));
               st_in = S_EXEC;
               if (!hit_in) slot_in = VS_W'(vc_ff);
            end else begin
               scan_in = scan_ff + VC_W'(1);
            end
            if (scan_ff == '0) nxt_in = stk_q;
         end
         S_EXEC: begin
            if (op_ff != OP_LOAD && op_ff != OP_SETVAR) nxt_in = stk_q;
            fin = 1'b1;
            case (op_ff)
               OP_PUSH: if (sc_ff >= SC_W'(STACK_DEPTH)) stat = ST_OVF;
                  else begin
                     stk_we = 1'b1; stk_wa = SP_W'(sc_ff); sc_in = sc_ff + SC_W'(1);
                  end
               OP_LOAD: if (!hit_ff) stat = ST_UNDEF;
                  else if (sc_ff >= SC_W'(STACK_DEPTH)) stat = ST_OVF;
                  else begin
                     stk_we = 1'b1; stk_wa = SP_W'(sc_ff); stk_wd = val_q;
                     sc_in = sc_ff + SC_W'(1);
                  end
               OP_SETVAR: if (sc_ff < SC_W'(1)) stat = ST_UNF;
                  else if (!hit_ff && vc_ff >= VC_W'(VAR_SLOTS)) stat = ST_FULL;
                  else begin
                     sc_in = sc_ff - SC_W'(1); val_we = 1'b1;
                     if (!hit_ff) begin
                        key_we = 1'b1; vc_in = vc_ff + VC_W'(1);
                     end
                  end
               OP_EMIT: if (sc_ff < SC_W'(1)) stat = ST_UNF;
                  else begin
                     sc_in = sc_ff - SC_W'(1); rpv_in = 1'b1; rpval_in = top_ff;
                  end
               OP_JMP, OP_JZ: begin
                  if (op_ff == OP_JZ) begin
                     if (sc_ff < SC_W'(1)) begin stat = ST_UNF; take = 1'b0; end
                     else begin sc_in = sc_ff - SC_W'(1); take = (top_ff == '0); end
                  end
                  if (stat == ST_RUN && take)
                     nidx = (jt[31] || jt >= {16'd0, plen_ff}) ? plen_ff : jt[15:0];
               end
               OP_HALT: stat = ST_HALT;
               default: if (op_ff >= OP_ADD && op_ff <= OP_GE) begin
                     if (sc_ff < SC_W'(2)) stat = ST_UNF;
                     else if (op_ff == OP_DIV && top_ff == '0) stat = ST_DIVZ;
                     else begin
                        fin = 1'b0; st_in = S_ALU;
                        alu_req = '{start: 1'b1, op: op_ff, a: stk_q, b: top_ff};
                     end
                  end else stat = ST_BADOP;
            endcase
         end
         S_ALU: if (alu_done) begin
               stk_we = 1'b1; stk_wa = SP_W'(sc_ff - SC_W'(2)); stk_wd = alu_res;
               sc_in = sc_ff - SC_W'(1); fin = 1'b1;
            end
         S_DONE: st_in = S_IDLE;
         default: st_in = S_IDLE;
      endcase

      if (fin && st_ff != S_RD1) begin
         if (stat != ST_RUN) begin
            nidx = idx_ff; stop_in = 1'b1; lst_in = stat;
         end else begin
            idx_in = nidx;
            if (nidx >= plen_ff) begin
               stat = ST_END; stop_in = 1'b1; lst_in = ST_END;
            end
         end
      end
      if (fin) begin
         st_in = S_IDLE; rv_in = 1'b1; rni_in = nidx; rst_in = stat;
         // a print that also reaches the end still carries its value
         if (!(st_ff == S_EXEC && op_ff == OP_EMIT &&
               (stat == ST_RUN || stat == ST_END))) begin
            rpv_in = 1'b0; rpval_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE; plen_ff <= '0; sc_ff <= '0; vc_ff <= '0; idx_ff <= '0;
         stop_ff <= 1'b0; lst_ff <= ST_RUN; rv_ff <= 1'b0;
      end else begin
         st_ff <= st_in; sc_ff <= sc_in; vc_ff <= vc_in; idx_ff <= idx_in;
         stop_ff <= stop_in; lst_ff <= lst_in; rv_ff <= rv_in;
         if (csr_valid && csr_ready) plen_ff <= csr_program_length;
      end
      if (req_valid && req_ready) begin
         op_ff <= req_cmd; opnd_ff <= req_operand; key_ff <= req_var_key[KEY_BITS-1:0];
         first_ff <= req_first;
      end
      top_ff <= top_in; nxt_ff <= nxt_in; scan_ff <= scan_in; hit_ff <= hit_in;
      slot_ff <= slot_in; rni_ff <= rni_in; rpv_ff <= rpv_in; rpval_ff <= rpval_in;
      rst_ff <= rst_in;
   end

   assign rsp_valid = rv_ff;
   assign rsp_next_index = rni_ff;
   assign rsp_print_valid = rpv_ff;
   assign rsp_print_value = rpval_ff;
   assign rsp_status = rst_ff;

   a_stack_bound: assert property (@(posedge clock) disable iff (reset)
      sc_ff <= SC_W'(STACK_DEPTH)) else $error("stack count overrun");
   a_var_bound: assert property (@(posedge clock) disable iff (reset)
      vc_ff <= VC_W'(VAR_SLOTS)) else $error("variable count overrun");
   a_print_ok: assert property (@(posedge clock) disable iff (reset)
      rv_ff && rpv_ff |-> rst_ff == ST_RUN || rst_ff == ST_END)
      else $error("print with fault status");
   a_busy_hold: assert property (@(posedge clock) disable iff (reset)
      st_ff != S_IDLE |-> !req_ready) else $error("ready while busy");
endmodule
`default_nettype wire
